// ===== rtl/kmch_pkg.sv =====
package kmch_pkg;

    // fixed-point and sizing constants
    localparam int FRAC_BITS = 24;
    localparam int CNT_W     = 17;
    localparam int GRP_W     = 16;
    localparam int TIME_W    = 32;
    localparam int HZ_W      = 25;
    localparam int SUM_W     = 48;
    localparam int DIV_W     = HZ_W + CNT_W;
    localparam int DCNT_W    = $clog2(DIV_W + 1);

    localparam logic [CNT_W-1:0] MAX_SUBJECTS = 17'd65536;
    localparam logic [HZ_W-1:0]  HZ_ONE       = 25'd1 << FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;

    // result kinds
    localparam logic KIND_SUBJECT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic              event_status;
        logic              final_subject;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [GRP_W-1:0]  group_index;
        logic [TIME_W-1:0] unique_time;
        logic [CNT_W-1:0]  at_risk;
        logic [HZ_W-1:0]   hazard;
        logic [SUM_W-1:0]  cum_term;
        logic              run_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CL_START,
        ST_CL_HZ_WAIT,
        ST_CL_MUL,
        ST_CL_TERM_START,
        ST_CL_TERM_WAIT,
        ST_CL_EMIT,
        ST_SUBJ
    } t_state;

endpackage

// ===== rtl/km_censoring_hazard_accumulator.sv =====
// Channel   | Handshake           | Payload
// ----------+---------------------+---------------------------------------
// subject   | push / full         | i_data  (t_in_item)
// result    | empty / pop         | o_data  (t_out_item), oldest first
// config    | i_cfg_we            | i_cfg_data: total_subjects
//
// A group close runs the shared 42-step serial divider for the hazard (skipped
// when all at risk are censored, hazard one), then for the sum term.
// Reset is synchronous, active low; total_subjects resets to 1.
// Subject and result queues are two beats deep; each side stalls independently.
module km_censoring_hazard_accumulator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  kmch_pkg::t_in_item    i_data,
    output logic                  empty,
    input  logic                  pop,
    output kmch_pkg::t_out_item   o_data,
    input  logic                  i_cfg_we,
    input  logic [kmch_pkg::CNT_W-1:0] i_cfg_data
);

    logic [kmch_pkg::CNT_W-1:0] r_total;
    logic                       in_valid;
    logic                       in_pop;
    kmch_pkg::t_in_item         in_item;
    logic                       out_push;
    logic                       out_full;
    kmch_pkg::t_out_item        out_item;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_total <= kmch_pkg::CNT_W'(1);
        else if (i_cfg_we) r_total <= i_cfg_data;
    end

    kmch_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .i_pop   (in_pop),
        .o_valid (in_valid),
        .o_data  (in_item)
    );

    kmch_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_total    (r_total),
        .i_in_valid (in_valid),
        .o_in_pop   (in_pop),
        .i_in_item  (in_item),
        .o_out_push (out_push),
        .i_out_full (out_full),
        .o_out_item (out_item)
    );

    kmch_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .o_full  (out_full),
        .i_data  (out_item),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

endmodule

// ===== rtl/kmch_front.sv =====
// Input side: two-entry queue that takes subject beats and hands them to the back end.
module kmch_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  kmch_pkg::t_in_item i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output kmch_pkg::t_in_item o_data
);

    kmch_pkg::t_in_item r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               do_push;
    logic               do_pop;

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = push && !full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/kmch_outq.sv =====
// Result side: two-entry queue between the sequencer and the consumer.
module kmch_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  kmch_pkg::t_out_item i_data,
    output logic                empty,
    input  logic                pop,
    output kmch_pkg::t_out_item o_data
);

    kmch_pkg::t_out_item r_mem [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign empty   = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/kmch_div.sv =====
// Restoring divider, one quotient bit per cycle.
module kmch_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kmch_pkg::DIV_W-1:0]    i_numer,
    input  logic [kmch_pkg::CNT_W-1:0]    i_denom,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [kmch_pkg::DIV_W-1:0]    o_quot
);

    logic [kmch_pkg::DIV_W-1:0]  r_num;
    logic [kmch_pkg::CNT_W-1:0]  r_den;
    logic [kmch_pkg::CNT_W-1:0]  r_rem;
    logic [kmch_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [kmch_pkg::CNT_W:0]    rem_sh;
    logic [kmch_pkg::CNT_W:0]    diff;
    logic                        ge;

    // one shift-subtract step
    assign rem_sh = {r_rem, r_num[kmch_pkg::DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == kmch_pkg::DCNT_W'(kmch_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_numer;
            r_den <= i_denom;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[kmch_pkg::CNT_W-1:0] : rem_sh[kmch_pkg::CNT_W-1:0];
            r_num <= {r_num[kmch_pkg::DIV_W-2:0], ge};
        end
    end

endmodule

// ===== rtl/kmch_back.sv =====
// Back end: group tracking, hazard and running sum, result sequencing.
module kmch_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [kmch_pkg::CNT_W-1:0]   i_total,
    input  logic                         i_in_valid,
    output logic                         o_in_pop,
    input  kmch_pkg::t_in_item           i_in_item,
    output logic                         o_out_push,
    input  logic                         i_out_full,
    output kmch_pkg::t_out_item          o_out_item
);

    kmch_pkg::t_state                  r_state;
    kmch_pkg::t_state                  n_state;
    kmch_pkg::t_in_item                r_item;
    logic                              r_open;
    logic                              r_final_close;
    logic [kmch_pkg::TIME_W-1:0]       r_gtime;
    logic [kmch_pkg::CNT_W-1:0]        r_remain;
    logic [kmch_pkg::CNT_W-1:0]        r_gar;
    logic [kmch_pkg::CNT_W-1:0]        r_cens;
    logic [kmch_pkg::GRP_W-1:0]        r_group;
    logic [kmch_pkg::SUM_W-1:0]        r_sum;
    logic [kmch_pkg::CNT_W-1:0]        r_n;
    logic [kmch_pkg::HZ_W-1:0]         r_hz;
    logic [kmch_pkg::DIV_W-1:0]        r_prod;

    logic [kmch_pkg::CNT_W-1:0]        ar;
    logic [kmch_pkg::CNT_W-1:0]        n_clamped;
    logic [kmch_pkg::CNT_W-1:0]        remain_dec;
    logic                              div_start;
    logic [kmch_pkg::DIV_W-1:0]        div_numer;
    logic                              div_busy;
    logic                              div_done;
    logic [kmch_pkg::DIV_W-1:0]        div_quot;
    logic [kmch_pkg::SUM_W:0]          sum_ext;

    assign ar         = (r_gar == '0) ? kmch_pkg::CNT_W'(1) : r_gar;
    assign remain_dec = (r_remain != '0) ? r_remain - 1'b1 : r_remain;
    assign sum_ext    = {1'b0, r_sum} + kmch_pkg::SUM_W'(div_quot) + (kmch_pkg::SUM_W + 1)'(0);

    // data set size, clamped to 1..MAX_SUBJECTS
    always_comb begin
        n_clamped = i_total;
        if (i_total == '0) n_clamped = kmch_pkg::CNT_W'(1);
        if (i_total > kmch_pkg::MAX_SUBJECTS) n_clamped = kmch_pkg::MAX_SUBJECTS;
    end

    // shared divider: hazard first, then the sum term
    assign div_numer = (r_state == kmch_pkg::ST_CL_START)
                     ? (kmch_pkg::DIV_W'(r_cens) << kmch_pkg::FRAC_BITS)
                     : r_prod;

    kmch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (ar),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= kmch_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // next state and outputs
    always_comb begin
        n_state    = r_state;
        o_in_pop   = 1'b0;
        o_out_push = 1'b0;
        div_start  = 1'b0;
        o_out_item = '0;
        unique case (r_state)
            kmch_pkg::ST_IDLE: begin
                o_in_pop = i_in_valid;
                if (i_in_valid) begin
                    if (r_open && (i_in_item.event_time != r_gtime))
                        n_state = kmch_pkg::ST_CL_START;
                    else
                        n_state = kmch_pkg::ST_SUBJ;
                end
            end
            kmch_pkg::ST_CL_START: begin
                if (r_cens >= ar) begin
                    n_state = kmch_pkg::ST_CL_MUL;
                end else begin
                    div_start = 1'b1;
                    n_state   = kmch_pkg::ST_CL_HZ_WAIT;
                end
            end
            kmch_pkg::ST_CL_HZ_WAIT: begin
                if (div_done) n_state = kmch_pkg::ST_CL_MUL;
            end
            kmch_pkg::ST_CL_MUL: begin
                n_state = kmch_pkg::ST_CL_TERM_START;
            end
            kmch_pkg::ST_CL_TERM_START: begin
                div_start = 1'b1;
                n_state   = kmch_pkg::ST_CL_TERM_WAIT;
            end
            kmch_pkg::ST_CL_TERM_WAIT: begin
                if (div_done) n_state = kmch_pkg::ST_CL_EMIT;
            end
            kmch_pkg::ST_CL_EMIT: begin
                o_out_push             = 1'b1;
                o_out_item.result_kind = kmch_pkg::KIND_SUMMARY;
                o_out_item.group_index = r_group;
                o_out_item.unique_time = r_gtime;
                o_out_item.at_risk     = ar;
                o_out_item.hazard      = r_hz;
                o_out_item.cum_term    = r_sum;
                o_out_item.run_end     = r_final_close;
                if (!i_out_full)
                    n_state = r_final_close ? kmch_pkg::ST_IDLE : kmch_pkg::ST_SUBJ;
            end
            kmch_pkg::ST_SUBJ: begin
                o_out_push             = 1'b1;
                o_out_item.result_kind = kmch_pkg::KIND_SUBJECT;
                o_out_item.group_index = r_group;
                o_out_item.run_end     = !r_item.final_subject;
                if (!i_out_full)
                    n_state = r_item.final_subject ? kmch_pkg::ST_CL_START
                                                   : kmch_pkg::ST_IDLE;
            end
            default: n_state = kmch_pkg::ST_IDLE;
        endcase
    end

    // group state and arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open        <= 1'b0;
            r_final_close <= 1'b0;
            r_gtime       <= '0;
            r_remain      <= '0;
            r_gar         <= '0;
            r_cens        <= '0;
            r_group       <= '0;
            r_sum         <= '0;
            r_n           <= kmch_pkg::CNT_W'(1);
        end else begin
            case (r_state)
                kmch_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item        <= i_in_item;
                        r_final_close <= 1'b0;
                        if (!r_open) begin
                            // first subject of a data set
                            r_n      <= n_clamped;
                            r_remain <= n_clamped;
                            r_gar    <= n_clamped;
                            r_group  <= '0;
                            r_sum    <= '0;
                            r_gtime  <= i_in_item.event_time;
                            r_cens   <= kmch_pkg::CNT_W'(!i_in_item.event_status);
                            r_open   <= 1'b1;
                        end else if (i_in_item.event_time == r_gtime) begin
                            // tie with the open group
                            if (!i_in_item.event_status && (r_cens != kmch_pkg::CNT_MAX))
                                r_cens <= r_cens + 1'b1;
                            r_remain <= remain_dec;
                        end
                    end
                end
                kmch_pkg::ST_CL_START: begin
                    if (r_cens >= ar) r_hz <= kmch_pkg::HZ_ONE;
                end
                kmch_pkg::ST_CL_HZ_WAIT: begin
                    if (div_done) r_hz <= div_quot[kmch_pkg::HZ_W-1:0];
                end
                kmch_pkg::ST_CL_MUL: begin
                    r_prod <= r_hz * r_n;
                end
                kmch_pkg::ST_CL_TERM_WAIT: begin
                    // saturating accumulate
                    if (div_done) begin
                        if (sum_ext[kmch_pkg::SUM_W]) r_sum <= '1;
                        else                          r_sum <= sum_ext[kmch_pkg::SUM_W-1:0];
                    end
                end
                kmch_pkg::ST_CL_EMIT: begin
                    if (!i_out_full) begin
                        if (r_final_close) begin
                            r_open <= 1'b0;
                        end else begin
                            // open the group of the pending subject
                            r_group  <= r_group + 1'b1;
                            r_remain <= remain_dec;
                            r_gar    <= remain_dec;
                            r_gtime  <= r_item.event_time;
                            r_cens   <= kmch_pkg::CNT_W'(!r_item.event_status);
                        end
                    end
                end
                kmch_pkg::ST_SUBJ: begin
                    if (!i_out_full && r_item.final_subject) r_final_close <= 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a summary never reports a hazard above one
    a_hz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_out_item.result_kind == kmch_pkg::KIND_SUMMARY)
            |-> (o_out_item.hazard <= kmch_pkg::HZ_ONE))
        else $error("hazard above one");
    // a subject result is only produced inside an open group
    a_subj_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmch_pkg::ST_SUBJ) |-> r_open)
        else $error("subject result without open group");
    // the divider is never restarted while running
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    // the running sum never decreases within a data set
    a_sum_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmch_pkg::ST_CL_TERM_WAIT && div_done) |=> (r_sum >= $past(r_sum)))
        else $error("running sum decreased");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Scoreboard: software copy of the censoring hazard state and the
    // queue of results the block owes us.
    class hazard_scoreboard;
        logic [kmch_pkg::CNT_W-1:0]  cfg_total;
        logic [kmch_pkg::CNT_W-1:0]  n_latched;
        logic [kmch_pkg::TIME_W-1:0] grp_time;
        logic [kmch_pkg::CNT_W-1:0]  remaining;
        logic [kmch_pkg::CNT_W-1:0]  grp_at_risk;
        logic [kmch_pkg::CNT_W-1:0]  censored;
        logic [kmch_pkg::GRP_W-1:0]  grp_idx;
        logic [kmch_pkg::SUM_W-1:0]  sum;
        bit                          open;
        kmch_pkg::t_out_item         pending[$];
        int                          errors;

        function new();
            cfg_total = kmch_pkg::CNT_W'(1);
            n_latched = kmch_pkg::CNT_W'(1);
            grp_time = '0;
            remaining = '0;
            grp_at_risk = '0;
            censored = '0;
            grp_idx = '0;
            sum = '0;
            open = 1'b0;
            errors = 0;
        endfunction

        function void set_total(logic [kmch_pkg::CNT_W-1:0] v);
            cfg_total = v;
        endfunction

        // summary beat for the open group, updates the running sum
        function void close_group(bit last);
            kmch_pkg::t_out_item r;
            logic [63:0] ar, hz, term;
            ar = (grp_at_risk != '0) ? 64'(grp_at_risk) : 64'd1;
            hz = (64'(censored) << kmch_pkg::FRAC_BITS) / ar;
            if (hz > (64'd1 << kmch_pkg::FRAC_BITS)) hz = 64'd1 << kmch_pkg::FRAC_BITS;
            term = (hz * 64'(n_latched)) / ar;
            if (term > (64'hFFFF_FFFF_FFFF - 64'(sum))) sum = '1;
            else sum = sum + term[kmch_pkg::SUM_W-1:0];
            r = '0;
            r.result_kind = kmch_pkg::KIND_SUMMARY;
            r.group_index = grp_idx;
            r.unique_time = grp_time;
            r.at_risk = ar[kmch_pkg::CNT_W-1:0];
            r.hazard = hz[kmch_pkg::HZ_W-1:0];
            r.cum_term = sum;
            r.run_end = last;
            pending.push_back(r);
        endfunction

        function void start_group(kmch_pkg::t_in_item it);
            grp_time = it.event_time;
            grp_at_risk = remaining;
            censored = kmch_pkg::CNT_W'(!it.event_status);
        endfunction

        function void note_subject(kmch_pkg::t_in_item it);
            kmch_pkg::t_out_item r;
            if (!open) begin
                if (cfg_total == '0) n_latched = kmch_pkg::CNT_W'(1);
                else if (cfg_total > kmch_pkg::MAX_SUBJECTS) n_latched = kmch_pkg::MAX_SUBJECTS;
                else n_latched = cfg_total;
                remaining = n_latched;
                grp_idx = '0;
                sum = '0;
                start_group(it);
                open = 1'b1;
            end else if (it.event_time == grp_time) begin
                if (!it.event_status && censored != kmch_pkg::CNT_MAX) censored++;
                if (remaining != '0) remaining--;
            end else begin
                close_group(1'b0);
                grp_idx++;
                if (remaining != '0) remaining--;
                start_group(it);
            end
            r = '0;
            r.result_kind = kmch_pkg::KIND_SUBJECT;
            r.group_index = grp_idx;
            r.run_end = !it.final_subject;
            pending.push_back(r);
            if (it.final_subject) begin
                close_group(1'b1);
                open = 1'b0;
            end
        endfunction

        function void check_result(kmch_pkg::t_out_item got);
            kmch_pkg::t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.result_kind !== e.result_kind) begin
                $error("result_kind exp %0d got %0d", e.result_kind, got.result_kind);
                errors++;
            end
            if (got.group_index !== e.group_index) begin
                $error("group_index exp %0d got %0d", e.group_index, got.group_index);
                errors++;
            end
            if (got.unique_time !== e.unique_time) begin
                $error("unique_time exp %0d got %0d", e.unique_time, got.unique_time);
                errors++;
            end
            if (got.at_risk !== e.at_risk) begin
                $error("at_risk exp %0d got %0d", e.at_risk, got.at_risk);
                errors++;
            end
            if (got.hazard !== e.hazard) begin
                $error("hazard exp %0d got %0d", e.hazard, got.hazard);
                errors++;
            end
            if (got.cum_term !== e.cum_term) begin
                $error("cum_term exp %0d got %0d", e.cum_term, got.cum_term);
                errors++;
            end
            if (got.run_end !== e.run_end) begin
                $error("run_end exp %0d got %0d", e.run_end, got.run_end);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    kmch_pkg::t_in_item          in_beat = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    kmch_pkg::t_out_item         out_beat;
    logic                        cfg_we = 1'b0;
    logic [kmch_pkg::CNT_W-1:0]  cfg_data = '0;

    hazard_scoreboard sb = new();
    int  cycles = 0;
    int  sink_idle_pct = 24;
    int  src_idle_pct = 24;
    int  hold_cycles = 0;
    logic hold_start = 1'b0;
    logic [kmch_pkg::TIME_W-1:0] cur_time;

    km_censoring_hazard_accumulator dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .push(push),
        .full(full),
        .i_data(in_beat),
        .empty(empty),
        .pop(pop),
        .o_data(out_beat),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // cycle limit watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // long receiver hold-off, counted down in cycles
    always @(posedge clk) begin
        if (hold_start)            hold_cycles <= 400;
        else if (hold_cycles > 0)  hold_cycles <= hold_cycles - 1;
    end

    // result side: random pop, nothing during a hold-off
    always @(posedge clk) begin
        if (rst_n && pop && !empty) sb.check_result(out_beat);
        if (hold_cycles > 0) pop <= 1'b0;
        else                 pop <= ($urandom_range(99) >= sink_idle_pct);
    end

    // one subject beat; waits until accepted, push stays up for a follow-on beat
    task automatic send_subject(logic [kmch_pkg::TIME_W-1:0] t, logic st, logic fin);
        kmch_pkg::t_in_item it;
        while ($urandom_range(99) < src_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        it.event_time = t;
        it.event_status = st;
        it.final_subject = fin;
        push <= 1'b1;
        in_beat <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_subject(it);
    endtask

    // drain, then write total_subjects
    task automatic write_total(logic [kmch_pkg::CNT_W-1:0] v);
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_total(v);
    endtask

    // one data set of len subjects with random ties and statuses
    task automatic send_set(int len, int tie_pct);
        for (int k = 0; k < len; k++) begin
            if (k != 0 && $urandom_range(99) >= tie_pct)
                cur_time = cur_time + $urandom_range(1, 5000);
            send_subject(cur_time, 1'($urandom_range(1)), k == len - 1);
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset value, extremes of time, time going backwards
        send_subject(32'd0, 1'b0, 1'b0);
        send_subject(32'd0, 1'b0, 1'b0);
        send_subject(32'hFFFF_FFFF, 1'b1, 1'b1);
        write_total(17'd3);
        send_subject(32'd100, 1'b0, 1'b0);
        send_subject(32'd50, 1'b0, 1'b0);
        send_subject(32'd50, 1'b1, 1'b0);
        send_subject(32'd50, 1'b0, 1'b0);
        send_subject(32'd60, 1'b0, 1'b0);
        send_subject(32'd70, 1'b0, 1'b1);
        // register changed mid data set takes effect next set
        send_subject(32'd5, 1'b0, 1'b0);
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= 17'd0;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_total(17'd0);
        send_subject(32'd6, 1'b0, 1'b1);
        send_subject(32'hAAAA_5555, 1'b0, 1'b1);
        write_total(17'h1FFFF);
        send_subject(32'h5555_AAAA, 1'b1, 1'b0);
        send_subject(32'h5555_AAAB, 1'b0, 1'b1);
        write_total(17'd65536);
        send_subject(32'd7, 1'b0, 1'b0);
        send_subject(32'd8, 1'b0, 1'b1);
        write_total(17'd1);
        send_subject(32'd9, 1'b0, 1'b0);
        send_subject(32'd9, 1'b0, 1'b1);

        // back pressure: sink holds off while we keep pushing
        write_total(17'd10);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        cur_time = $urandom;
        send_set(10, 20);

        // random data sets over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            write_total($urandom_range(1) ? 17'($urandom_range(1, 40)) :
                        17'($urandom_range(0, 17'h1FFFF)));
            if (ph == 3) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct = 24;
                sink_idle_pct = 24;
            end
            for (int s = 0; s < 5; s++) begin
                cur_time = $urandom;
                send_set($urandom_range(1, 14), $urandom_range(0, 60));
            end
        end

        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/kmch_pkg.sv
rtl/kmch_front.sv
rtl/kmch_outq.sv
rtl/kmch_div.sv
rtl/kmch_back.sv
rtl/km_censoring_hazard_accumulator.sv
test/testbench.sv
